// ----- rtl/core/s3mpsd_pkg.sv -----
// ============================================================================
// s3mpsd_pkg
// Shared types and constants for the packed pattern stream decoder.
// ============================================================================
package s3mpsd_pkg;

    localparam int ROWS_PER_PATTERN = 64;
    localparam int ROW_W = ($clog2(ROWS_PER_PATTERN + 1) > 6) ?
                           $clog2(ROWS_PER_PATTERN + 1) : 7;

    localparam logic [7:0] NOTE_KEY_OFF_IN = 8'd254;
    localparam logic [7:0] NOTE_EMPTY      = 8'd255;
    localparam logic [7:0] NOTE_KEY_OFF    = 8'd120;
    localparam logic [7:0] NOTE_MAX        = 8'd195;
    localparam logic [7:0] INST_NONE       = 8'd255;
    localparam logic [7:0] MACH_NONE       = 8'd255;
    localparam logic [7:0] MACH_SET        = 8'd0;
    localparam logic [7:0] CMD_NONE        = 8'd0;
    localparam logic [7:0] CMD_VOLUME      = 8'h0C;
    localparam logic [7:0] VOL_MAX         = 8'd64;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIZEHI,
        PH_FLAG,
        PH_NOTE,
        PH_INST,
        PH_VOL,
        PH_FX1,
        PH_FX2
    } t_phase;

endpackage

// ----- rtl/core/s3m_pattern_stream_decoder.sv -----
// ============================================================================
// s3m_pattern_stream_decoder
// Decodes a packed tracker pattern stream into one beat per pattern entry.
// ============================================================================
// Usage:
//   Input channel: one stream byte per beat (i_data_byte), with
//   i_pattern_start marking the first size byte of a pattern and
//   i_pattern_number sampled on that beat. A start beat always restarts
//   decoding and drops any partial entry.
//   Output channel: one beat per completed entry, carrying pattern,
//   channel, row, translated note, instrument, machine, command, parameter.
//   Path: the input beat that completes an entry is held in the input
//   register, and its result is then written to the result register.
//   Throughput: one input byte per cycle unless the receiver stalls; the
//   per-byte state update is a single pass of logic between the two registers.
//   Receiver stall: the result register holds its beat; the input register
//   keeps its beat, or takes one more if empty, after which o_stall rises.
//   Reset: the decoder waits for a start beat; both registers are empty.
// ============================================================================
module s3m_pattern_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_pattern_start,
    input  logic [7:0] i_pattern_number,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_pattern,
    output logic [4:0] o_out_channel,
    output logic [5:0] o_out_row,
    output logic [7:0] o_out_note,
    output logic [7:0] o_out_instrument,
    output logic [7:0] o_out_machine,
    output logic [7:0] o_out_command,
    output logic [7:0] o_out_parameter
);
    import s3mpsd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;
    logic [7:0]       r_in_pattern;

    t_phase           r_phase, n_phase;
    logic [ROW_W-1:0] r_row, n_row;
    logic [2:0]       r_flags, n_flags;
    logic [4:0]       r_chan, n_chan;
    logic [7:0]       r_pattern, n_pattern;
    logic [7:0]       r_note, n_note;
    logic [7:0]       r_inst, n_inst;
    logic             r_mach_set, n_mach_set;
    logic             r_vol_set, n_vol_set;
    logic [7:0]       r_param, n_param;

    logic             r_out_valid;
    logic [7:0]       r_out_pattern;
    logic [4:0]       r_out_channel;
    logic [5:0]       r_out_row;
    logic [7:0]       r_out_note;
    logic [7:0]       r_out_inst;
    logic             r_out_mach_set;
    logic             r_out_vol_set;
    logic [7:0]       r_out_param;

    logic             w_adv;
    logic             w_emit;
    logic [ROW_W-1:0] w_row_inc;
    logic [7:0]       w_note_xl;
    logic [13:0]      w_vol_prod;

    assign w_adv   = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && !w_adv;

    assign w_row_inc  = r_row + ROW_W'(1);
    assign w_vol_prod = 14'(r_in_byte) * 14'd255;

    always_comb begin
        if (r_in_byte == NOTE_KEY_OFF_IN) begin
            w_note_xl = NOTE_KEY_OFF;
        end else if (r_in_byte == NOTE_EMPTY) begin
            w_note_xl = NOTE_EMPTY;
        end else begin
            w_note_xl = 8'(r_in_byte[7:4]) * 8'd12 + 8'(r_in_byte[3:0]);
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_in_start) begin
            n_phase = PH_SIZEHI;
        end else begin
            case (r_phase)
                PH_SIZEHI: n_phase = PH_FLAG;
                PH_FLAG: begin
                    if (r_in_byte == 8'd0) begin
                        if (w_row_inc >= ROW_W'(ROWS_PER_PATTERN)) n_phase = PH_IDLE;
                    end else if (r_in_byte[5]) begin
                        n_phase = PH_NOTE;
                    end else if (r_in_byte[6]) begin
                        n_phase = PH_VOL;
                    end else if (r_in_byte[7]) begin
                        n_phase = PH_FX1;
                    end
                end
                PH_NOTE: n_phase = PH_INST;
                PH_INST: begin
                    if (r_flags[1]) begin
                        n_phase = PH_VOL;
                    end else if (r_flags[2]) begin
                        n_phase = PH_FX1;
                    end else begin
                        n_phase = PH_FLAG;
                    end
                end
                PH_VOL:  n_phase = r_flags[2] ? PH_FX1 : PH_FLAG;
                PH_FX1:  n_phase = PH_FX2;
                PH_FX2:  n_phase = PH_FLAG;
                default: n_phase = r_phase;
            endcase
        end
    end

    // entry datapath and emit
    always_comb begin
        n_row      = r_row;
        n_flags    = r_flags;
        n_chan     = r_chan;
        n_pattern  = r_pattern;
        n_note     = r_note;
        n_inst     = r_inst;
        n_mach_set = r_mach_set;
        n_vol_set  = r_vol_set;
        n_param    = r_param;
        w_emit     = 1'b0;
        if (r_in_start) begin
            n_pattern  = r_in_pattern;
            n_row      = '0;
            n_flags    = '0;
            n_chan     = '0;
            n_note     = NOTE_EMPTY;
            n_inst     = INST_NONE;
            n_mach_set = 1'b0;
            n_vol_set  = 1'b0;
            n_param    = '0;
        end else begin
            case (r_phase)
                PH_FLAG: begin
                    if (r_in_byte == 8'd0) begin
                        n_row = w_row_inc;
                    end else begin
                        n_chan     = r_in_byte[4:0];
                        n_flags    = r_in_byte[7:5];
                        n_note     = NOTE_EMPTY;
                        n_inst     = INST_NONE;
                        n_mach_set = 1'b0;
                        n_vol_set  = 1'b0;
                        n_param    = '0;
                        w_emit     = (r_in_byte[7:5] == 3'd0);
                    end
                end
                PH_NOTE: n_note = w_note_xl;
                PH_INST: begin
                    n_inst     = r_in_byte - 8'd1;
                    n_mach_set = 1'b1;
                    w_emit     = !r_flags[1] && !r_flags[2];
                end
                PH_VOL: begin
                    if (r_in_byte <= VOL_MAX) begin
                        n_param    = w_vol_prod[13:6];
                        n_mach_set = 1'b1;
                        n_vol_set  = 1'b1;
                    end
                    w_emit = !r_flags[2];
                end
                PH_FX2:  w_emit = 1'b1;
                default: w_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in_byte    <= i_data_byte;
            r_in_start   <= i_pattern_start;
            r_in_pattern <= i_pattern_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_row      <= '0;
            r_flags    <= '0;
            r_chan     <= '0;
            r_pattern  <= '0;
            r_note     <= NOTE_EMPTY;
            r_inst     <= INST_NONE;
            r_mach_set <= 1'b0;
            r_vol_set  <= 1'b0;
            r_param    <= '0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_flags   <= n_flags;
            r_chan    <= n_chan;
            r_pattern <= n_pattern;
            if (w_emit) begin
                r_note     <= NOTE_EMPTY;
                r_inst     <= INST_NONE;
                r_mach_set <= 1'b0;
                r_vol_set  <= 1'b0;
                r_param    <= '0;
            end else begin
                r_note     <= n_note;
                r_inst     <= n_inst;
                r_mach_set <= n_mach_set;
                r_vol_set  <= n_vol_set;
                r_param    <= n_param;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_emit) begin
            r_out_pattern  <= n_pattern;
            r_out_channel  <= n_chan;
            r_out_row      <= n_row[5:0];
            r_out_note     <= n_note;
            r_out_inst     <= n_inst;
            r_out_mach_set <= n_mach_set;
            r_out_vol_set  <= n_vol_set;
            r_out_param    <= n_param;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_pattern    = r_out_pattern;
    assign o_out_channel    = r_out_channel;
    assign o_out_row        = r_out_row;
    assign o_out_note       = r_out_note;
    assign o_out_instrument = r_out_inst;
    assign o_out_machine    = r_out_mach_set ? MACH_SET : MACH_NONE;
    assign o_out_command    = r_out_vol_set ? CMD_VOLUME : CMD_NONE;
    assign o_out_parameter  = r_out_param;

endmodule

// ----- rtl/core/s3mpsd_checker.sv -----
// ============================================================================
// s3mpsd_checker
// Port-level checks on the pattern stream decoder, bound to the decoder module.
// ============================================================================
module s3mpsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_note,
    input logic [7:0] o_out_machine,
    input logic [7:0] o_out_command,
    input logic [7:0] o_out_parameter
);
    import s3mpsd_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_hold_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_note))
        else $error("output note changed while stalled");

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_note <= NOTE_MAX || o_out_note == NOTE_EMPTY))
        else $error("translated note out of range");

    a_cmd_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out_command == CMD_NONE && o_out_parameter == 8'd0) ||
                     (o_out_command == CMD_VOLUME && o_out_machine == MACH_SET)))
        else $error("volume command without machine or with stray parameter");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");

endmodule

bind s3m_pattern_stream_decoder s3mpsd_checker u_s3mpsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_out_note      (o_out_note),
    .o_out_machine   (o_out_machine),
    .o_out_command   (o_out_command),
    .o_out_parameter (o_out_parameter)
);

// ----- dv/s3m_pattern_stream_decoder_tb.sv -----
// ============================================================================
// s3m_pattern_stream_decoder_tb
// Drives packed pattern byte streams into the decoder and checks each
// decoded entry beat against a cycle-free model of the row/entry walk.
// Streams mix whole patterns, cut-off patterns, restarts in mid-entry and
// stray bytes. The sender idles and the receiver stalls at random.
// ============================================================================
module s3m_pattern_stream_decoder_tb;
    import s3mpsd_pkg::*;

    typedef struct packed {
        logic [7:0] pattern;
        logic [4:0] channel;
        logic [5:0] row;
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] machine;
        logic [7:0] command;
        logic [7:0] param;
    } t_pattern_entry;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [7:0] number;
    } t_stream_beat;

    class entry_scoreboard;
        t_pattern_entry   pending_entries[$];
        int               errors;
        t_phase           step;
        logic [ROW_W-1:0] rows_done;
        logic [2:0]       parts;
        logic [4:0]       chan;
        logic [7:0]       pat;
        t_pattern_entry   cur;

        function new();
            errors    = 0;
            step      = PH_IDLE;
            rows_done = '0;
            parts     = '0;
            chan      = '0;
            pat       = '0;
            clear_entry();
        endfunction

        function void clear_entry();
            cur            = '0;
            cur.note       = NOTE_EMPTY;
            cur.instrument = INST_NONE;
            cur.machine    = MACH_NONE;
            cur.command    = CMD_NONE;
            cur.param      = 8'd0;
        endfunction

        function void close_entry();
            cur.pattern = pat;
            cur.channel = chan;
            cur.row     = rows_done[5:0];
            pending_entries.push_back(cur);
            clear_entry();
            step = PH_FLAG;
        endfunction

        function void finish_part(t_phase done);
            if (done < PH_VOL && parts[1]) begin
                step = PH_VOL;
            end else if (done < PH_FX1 && parts[2]) begin
                step = PH_FX1;
            end else begin
                close_entry();
            end
        endfunction

        function void decode_byte(logic [7:0] b, logic start, logic [7:0] num);
            if (start) begin
                pat       = num;
                rows_done = '0;
                parts     = '0;
                chan      = '0;
                clear_entry();
                step      = PH_SIZEHI;
                return;
            end
            case (step)
                PH_SIZEHI: begin
                    step = PH_FLAG;
                end
                PH_FLAG: begin
                    if (b == 8'd0) begin
                        rows_done = rows_done + 1'b1;
                        if (rows_done >= ROWS_PER_PATTERN) step = PH_IDLE;
                    end else begin
                        chan  = b[4:0];
                        parts = b[7:5];
                        clear_entry();
                        if (parts[0]) step = PH_NOTE;
                        else finish_part(PH_INST);
                    end
                end
                PH_NOTE: begin
                    if (b == NOTE_KEY_OFF_IN) cur.note = NOTE_KEY_OFF;
                    else if (b == NOTE_EMPTY) cur.note = NOTE_EMPTY;
                    else cur.note = 8'(int'(b[7:4]) * 12 + int'(b[3:0]));
                    step = PH_INST;
                end
                PH_INST: begin
                    cur.instrument = b - 8'd1;
                    cur.machine    = MACH_SET;
                    finish_part(PH_INST);
                end
                PH_VOL: begin
                    if (b <= VOL_MAX) begin
                        cur.param   = 8'(int'(b) * 255 / 64);
                        cur.machine = MACH_SET;
                        cur.command = CMD_VOLUME;
                    end
                    finish_part(PH_VOL);
                end
                PH_FX1: begin
                    step = PH_FX2;
                end
                PH_FX2: begin
                    close_entry();
                end
                default: begin
                end
            endcase
        endfunction

        function void check_field(string name, int exp_val, int got_val);
            if (exp_val != got_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_entry(t_pattern_entry got);
            t_pattern_entry want;
            if (pending_entries.size() == 0) begin
                $error("unexpected entry beat: pattern %0d channel %0d row %0d",
                       got.pattern, got.channel, got.row);
                errors++;
                return;
            end
            want = pending_entries.pop_front();
            check_field("out_pattern", want.pattern, got.pattern);
            check_field("out_channel", want.channel, got.channel);
            check_field("out_row", want.row, got.row);
            check_field("out_note", want.note, got.note);
            check_field("out_instrument", want.instrument, got.instrument);
            check_field("out_machine", want.machine, got.machine);
            check_field("out_command", want.command, got.command);
            check_field("out_parameter", want.param, got.param);
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 150;
    localparam int STREAM_ITEMS = 550;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_SQUARE,
        RX_HEAVY
    } t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_pattern_start = 1'b0;
    logic [7:0] i_pattern_number = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_pattern;
    logic [4:0] o_out_channel;
    logic [5:0] o_out_row;
    logic [7:0] o_out_note;
    logic [7:0] o_out_instrument;
    logic [7:0] o_out_machine;
    logic [7:0] o_out_command;
    logic [7:0] o_out_parameter;

    entry_scoreboard sb;
    t_stream_beat    stream_q[$];
    int              beats_in = 0;
    int              stray_beats = 0;
    int              idle_cycles = 0;
    int              hold_left = 0;
    logic            hold_done = 1'b0;
    logic [7:0]      rx_cycle = 8'd0;
    t_rx_mode        rx_mode = RX_OPEN;

    s3m_pattern_stream_decoder DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_pattern_start  (i_pattern_start),
        .i_pattern_number (i_pattern_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_pattern    (o_out_pattern),
        .o_out_channel    (o_out_channel),
        .o_out_row        (o_out_row),
        .o_out_note       (o_out_note),
        .o_out_instrument (o_out_instrument),
        .o_out_machine    (o_out_machine),
        .o_out_command    (o_out_command),
        .o_out_parameter  (o_out_parameter)
    );

    always #5 i_clk = ~i_clk;

    task automatic add_beat(input logic [7:0] d, input logic s, input logic [7:0] n);
        t_stream_beat b;
        b.data   = d;
        b.start  = s;
        b.number = n;
        stream_q.push_back(b);
    endtask

    task automatic add_data(input logic [7:0] d);
        add_beat(d, 1'b0, 8'($urandom));
    endtask

    task automatic add_entry(input logic [4:0] ch, input logic [2:0] bits);
        if (bits == 3'd0 && ch == 5'd0) ch = 5'd1;
        add_data({bits, ch});
        if (bits[0]) begin
            case ($urandom_range(0, 9))
                0: add_data(NOTE_KEY_OFF_IN);
                1: add_data(NOTE_EMPTY);
                default: add_data(8'($urandom));
            endcase
            add_data(8'($urandom));
        end
        if (bits[1]) begin
            if ($urandom_range(0, 1) == 0) add_data(8'($urandom_range(0, VOL_MAX)));
            else add_data(8'($urandom));
        end
        if (bits[2]) begin
            add_data(8'($urandom));
            add_data(8'($urandom));
        end
    endtask

    task automatic add_pattern(input logic [7:0] num, input int rows, input int density);
        int n;
        add_beat(8'($urandom), 1'b1, num);
        add_data(8'($urandom));
        for (int r = 0; r < rows; r++) begin
            n = ($urandom_range(0, 99) < density) ? $urandom_range(1, 3) : 0;
            for (int e = 0; e < n; e++) begin
                add_entry(5'($urandom), 3'($urandom));
            end
            add_data(8'd0);
        end
    endtask

    task automatic build_stream();
        add_data(8'hFF);
        add_data(8'h00);
        add_beat(8'hFF, 1'b1, 8'hFF);
        add_data(8'h00);
        add_data(8'h3F);
        add_data(NOTE_KEY_OFF_IN);
        add_data(8'h00);
        add_data(8'h20);
        add_data(NOTE_EMPTY);
        add_data(8'hFF);
        add_data(8'h45);
        add_data(VOL_MAX);
        add_data(8'h40);
        add_data(VOL_MAX + 8'd1);
        add_data(8'h83);
        add_data(8'hAA);
        add_data(8'h55);
        add_data(8'hF1);
        add_data(8'hFD);
        add_data(8'h01);
        add_data(8'd0);
        add_data(8'hA2);
        add_data(8'h01);
        add_data(8'd0);
        add_beat(8'h00, 1'b1, 8'h00);
        add_data(8'hFF);
        add_data(8'h60);
        add_data(8'h23);
        add_beat(8'h12, 1'b1, 8'hA5);
        add_data(8'h34);
        add_data(8'h1F);
        add_data(8'd0);
        while (stream_q.size() - stray_beats < STREAM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    add_pattern(8'($urandom), ROWS_PER_PATTERN, $urandom_range(10, 40));
                    for (int k = $urandom_range(0, 4); k > 0; k--) begin
                        add_data(8'($urandom));
                        stray_beats++;
                    end
                end
                6, 7: begin
                    add_pattern(8'($urandom), $urandom_range(0, 8), 50);
                    if ($urandom_range(0, 1) == 0) begin
                        add_data(8'hE0 | 8'($urandom_range(0, 31)));
                        add_data(8'($urandom));
                    end
                end
                8: begin
                    for (int k = $urandom_range(1, 6); k > 0; k--) add_data(8'($urandom));
                end
                default: begin
                    for (int k = $urandom_range(1, 6); k > 0; k--) begin
                        add_beat(8'($urandom), ($urandom_range(0, 7) == 0), 8'($urandom));
                    end
                end
            endcase
        end
    endtask

    task automatic send_stream();
        t_stream_beat b;
        int burst;
        int gap;
        while (stream_q.size() > 0) begin
            burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
            for (int k = 0; k < burst && stream_q.size() > 0; k++) begin
                b = stream_q.pop_front();
                i_valid          <= 1'b1;
                i_data_byte      <= b.data;
                i_pattern_start  <= b.start;
                i_pattern_number <= b.number;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                sb.decode_byte(b.data, b.start, b.number);
                beats_in++;
            end
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    // receiver stall pattern, with one long hold-off to back up the input
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && beats_in >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            if (rx_cycle[5:0] == 6'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:   i_stall <= 1'b0;
                RX_SPARSE: i_stall <= ($urandom_range(0, 3) == 0);
                RX_SQUARE: i_stall <= rx_cycle[2];
                default:   i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_entry('{o_out_pattern, o_out_channel, o_out_row, o_out_note,
                             o_out_instrument, o_out_machine, o_out_command,
                             o_out_parameter});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        sb = new();
        build_stream();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_stream();
        while (sb.pending_entries.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pending_entries.size() != 0) begin
            $error("%0d entries never arrived", sb.pending_entries.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- s3m_pattern_stream_decoder.f -----
rtl/core/s3mpsd_pkg.sv
rtl/core/s3m_pattern_stream_decoder.sv
rtl/core/s3mpsd_checker.sv
dv/s3m_pattern_stream_decoder_tb.sv
